>>> hw/rtl/tbc_pkg.sv
package tbc_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_BINS_DEF    = 16;
    localparam int LENGTH_BITS_DEF = 32;

    // Fixed port widths.
    localparam int LEN_PORT_W = 32;
    localparam int SLOT_W     = 5;
    localparam int CFG_W      = 5;
    localparam int INDEX_W    = 12;
    localparam int STATUS_W   = 2;

    // Reset value of the bins-in-use register.
    localparam logic [CFG_W-1:0] BINS_RESET = 5'd16;

    // Item function codes.
    localparam logic FUNC_LOAD     = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_DEGEN  = 2'd1,
        ST_NO_BIN = 2'd2
    } t_status;

    // Edge table write control.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] slot;
    } t_edge_wr;

endpackage

>>> hw/rtl/tbc_bin_lookup.sv
module tbc_bin_lookup #(
    parameter int MAX_BINS    = tbc_pkg::MAX_BINS_DEF,
    parameter int LENGTH_BITS = tbc_pkg::LENGTH_BITS_DEF,
    localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
    input  logic                              i_clk,
    input  tbc_pkg::t_edge_wr                 i_wr,
    input  logic [LENGTH_BITS-1:0]            i_wr_value,
    input  logic [2:0][LENGTH_BITS-1:0]       i_len,
    input  logic [tbc_pkg::CFG_W-1:0]         i_bins,
    output logic [2:0]                        o_found,
    output logic [2:0][BIN_W-1:0]             o_idx
);

    logic [LENGTH_BITS-1:0]    r_edge [MAX_BINS+1];
    logic [2:0][MAX_BINS-1:0]  n_hit;
    logic [2:0][MAX_BINS-1:0]  r_hit;
    logic [2:0]                n_found;
    logic [2:0][BIN_W-1:0]     n_idx;
    logic [2:0]                r_found;
    logic [2:0][BIN_W-1:0]     r_idx;

    // The compares run against the table into r_hit, and the highest hit is
    // encoded from r_hit into r_found and r_idx. A table write lands at the
    // edge where its own transaction passes the compare stage: after the item
    // ahead of it has compared and before the item behind it does, so items
    // see the table in transaction order.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= MAX_BINS; i++) begin
            if (i_wr.we && (int'(i_wr.slot) == i)) begin
                r_edge[i] <= i_wr_value;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            for (int i = 0; i < MAX_BINS; i++) begin
                n_hit[l][i] = (i < int'(i_bins)) && (i_len[l] >= r_edge[i])
                              && (i_len[l] < r_edge[i+1]);
            end
        end
    end

    // The highest matching bin wins.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_found[l] = 1'b0;
            n_idx[l]   = '0;
            for (int i = 0; i < MAX_BINS; i++) begin
                if (r_hit[l][i]) begin
                    n_found[l] = 1'b1;
                    n_idx[l]   = BIN_W'(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= n_hit;
        r_found <= n_found;
        r_idx   <= n_idx;
    end

    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

>>> hw/rtl/triangle_bin_classifier_unit.sv
// Triangle bin classifier. An item is taken at every clock edge where start
// is high; busy never rises, because the pipeline never stalls. A load item
// writes one squared bin edge, if its slot lies within the table, and
// returns nothing. A classify item sorts its three squared lengths, rejects
// degenerate triangles exactly, bins each length and returns the flat bin
// index or a status code. The result appears on o_status and o_triangle_index
// with o_done high for exactly one cycle; the receiver must take it then,
// since there is no way to hold it off. One item per cycle is sustained,
// set by the six-stage pipeline with one 32x32 multiplier in each of two
// stages.
// Edge loads affect every classify item accepted after them. Edges must be
// loaded before they are used. The bins-in-use register may be written only
// while no classify transaction is in flight; its write port is always ready.
module triangle_bin_classifier_unit #(
    parameter int MAX_BINS    = tbc_pkg::MAX_BINS_DEF,
    parameter int LENGTH_BITS = tbc_pkg::LENGTH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Item channel.
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_func,
    input  logic [tbc_pkg::LEN_PORT_W-1:0]     i_len_a,
    input  logic [tbc_pkg::LEN_PORT_W-1:0]     i_len_b,
    input  logic [tbc_pkg::LEN_PORT_W-1:0]     i_len_c,
    input  logic [tbc_pkg::SLOT_W-1:0]         i_edge_slot,
    input  logic [tbc_pkg::LEN_PORT_W-1:0]     i_edge_value,
    // Result channel.
    output logic                               o_done,
    output logic [tbc_pkg::STATUS_W-1:0]       o_status,
    output logic [tbc_pkg::INDEX_W-1:0]        o_triangle_index,
    // Configuration channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tbc_pkg::CFG_W-1:0]          i_cfg_data
);

    localparam int LB    = LENGTH_BITS;
    localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int IW    = tbc_pkg::INDEX_W;

    // The pipeline never stalls and configuration is always accepted.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration: bins per side, clamped to the table size.
    logic [tbc_pkg::CFG_W-1:0] r_bins_cfg;
    logic [tbc_pkg::CFG_W-1:0] n_bins;
    logic [IW-1:0]             n_nn;
    logic [IW-1:0]             r_nn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins_cfg <= tbc_pkg::BINS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bins_cfg <= i_cfg_data;
        end
    end

    assign n_bins = (int'(r_bins_cfg) > MAX_BINS) ? tbc_pkg::CFG_W'(MAX_BINS) : r_bins_cfg;
    assign n_nn   = IW'(IW'(n_bins) * IW'(n_bins));

    // Stage valid bits. Stages 1 and 2 carry every transaction, since loads
    // write the table in stage 2; from stage 3 on only classify items travel.
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld;
    logic r_s1_func, r_s2_func;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && (r_s2_func == tbc_pkg::FUNC_CLASSIFY);
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
        end
    end

    // Stage 1: capture the accepted transaction, keeping the low length bits.
    logic [LB-1:0]              r_s1_a, r_s1_b, r_s1_c, r_s1_value;
    logic [tbc_pkg::SLOT_W-1:0] r_s1_slot;

    // Stage 2: sorted lengths, or the load's slot and value.
    logic [LB-1:0]              n_min, n_mid, n_max;
    logic [LB-1:0]              r_s2_a, r_s2_b, r_s2_c, r_s2_value;
    logic [tbc_pkg::SLOT_W-1:0] r_s2_slot;

    // Stage 3: a+b and a*b.
    logic [LB:0]                r_s3_sum;
    logic [2*LB-1:0]            r_s3_ab;
    logic [LB-1:0]              r_s3_c;

    // Stage 4: d = c-a-b and whether it is not negative.
    logic [LB-1:0]              r_s4_d;
    logic                       r_s4_ge;
    logic [2*LB-1:0]            r_s4_ab;

    // Stage 5: d*d and the flat bin index.
    logic [2*LB-1:0]            r_s5_dd;
    logic [2*LB-1:0]            r_s5_ab;
    logic                       r_s5_ge;
    logic                       r_s5_all;
    logic [IW-1:0]              r_s5_idx;

    // Stage 6: the result registers.
    tbc_pkg::t_status           r_s6_status;
    logic [IW-1:0]              r_s6_idx;

    logic                       n_degen;
    tbc_pkg::t_status           n_status;

    // Sorting: the minimum and maximum from pairwise compares, and the
    // middle value as what is left of the three.
    always_comb begin
        if ((r_s1_a <= r_s1_b) && (r_s1_a <= r_s1_c)) begin
            n_min = r_s1_a;
        end else if (r_s1_b <= r_s1_c) begin
            n_min = r_s1_b;
        end else begin
            n_min = r_s1_c;
        end
        if ((r_s1_a >= r_s1_b) && (r_s1_a >= r_s1_c)) begin
            n_max = r_s1_a;
        end else if (r_s1_b >= r_s1_c) begin
            n_max = r_s1_b;
        end else begin
            n_max = r_s1_c;
        end
        n_mid = r_s1_a ^ r_s1_b ^ r_s1_c ^ n_min ^ n_max;
    end

    // Bin search: compares in stage 3, encoded index in stage 4.
    tbc_pkg::t_edge_wr              edge_wr;
    logic [2:0][LB-1:0]             bin_len;
    logic [2:0]                     bin_found;
    logic [2:0][BIN_W-1:0]          bin_idx;

    assign edge_wr.we   = r_s2_vld && (r_s2_func == tbc_pkg::FUNC_LOAD)
                          && (int'(r_s2_slot) <= MAX_BINS);
    assign edge_wr.slot = r_s2_slot;
    assign bin_len[0]   = r_s2_a;
    assign bin_len[1]   = r_s2_b;
    assign bin_len[2]   = r_s2_c;

    tbc_bin_lookup #(
        .MAX_BINS    (MAX_BINS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_lookup (
        .i_clk      (i_clk),
        .i_wr       (edge_wr),
        .i_wr_value (r_s2_value),
        .i_len      (bin_len),
        .i_bins     (n_bins),
        .o_found    (bin_found),
        .o_idx      (bin_idx)
    );

    // The triangle test: degenerate when c >= a+b and 4ab <= d*d, which for
    // integers is ab <= floor(d*d/4).
    assign n_degen = r_s5_ge && (r_s5_ab <= (r_s5_dd >> 2));

    always_comb begin
        if (n_degen) begin
            n_status = tbc_pkg::ST_DEGEN;
        end else if (!r_s5_all) begin
            n_status = tbc_pkg::ST_NO_BIN;
        end else begin
            n_status = tbc_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nn <= n_nn;

        r_s1_func  <= i_func;
        r_s1_a     <= i_len_a[LB-1:0];
        r_s1_b     <= i_len_b[LB-1:0];
        r_s1_c     <= i_len_c[LB-1:0];
        r_s1_slot  <= i_edge_slot;
        r_s1_value <= i_edge_value[LB-1:0];

        r_s2_func  <= r_s1_func;
        r_s2_a     <= n_min;
        r_s2_b     <= n_mid;
        r_s2_c     <= n_max;
        r_s2_slot  <= r_s1_slot;
        r_s2_value <= r_s1_value;

        r_s3_sum <= {1'b0, r_s2_a} + {1'b0, r_s2_b};
        r_s3_ab  <= {{LB{1'b0}}, r_s2_a} * {{LB{1'b0}}, r_s2_b};
        r_s3_c   <= r_s2_c;

        r_s4_ge <= ({1'b0, r_s3_c} >= r_s3_sum);
        r_s4_d  <= r_s3_c - r_s3_sum[LB-1:0];
        r_s4_ab <= r_s3_ab;

        r_s5_dd  <= {{LB{1'b0}}, r_s4_d} * {{LB{1'b0}}, r_s4_d};
        r_s5_ab  <= r_s4_ab;
        r_s5_ge  <= r_s4_ge;
        r_s5_all <= &bin_found;
        r_s5_idx <= IW'(IW'(bin_idx[2]) + IW'(bin_idx[1]) * IW'(n_bins)
                        + IW'(bin_idx[0]) * r_nn);

        r_s6_status <= n_status;
        r_s6_idx    <= (n_status == tbc_pkg::ST_OK) ? r_s5_idx : '0;
    end

    assign o_done           = r_s6_vld;
    assign o_status         = r_s6_status;
    assign o_triangle_index = r_s6_idx;

    // Every classify transaction yields exactly one result.
    a_classify_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == tbc_pkg::FUNC_CLASSIFY)) |-> ##6 o_done)
        else $error("classify transaction produced no result");

    // A load transaction never produces a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == tbc_pkg::FUNC_LOAD)) |-> ##6 !o_done)
        else $error("load transaction produced a result");

    // Three zero lengths always form a degenerate triangle.
    a_zero_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == tbc_pkg::FUNC_CLASSIFY) && (i_len_a == '0)
         && (i_len_b == '0) && (i_len_c == '0))
        |-> ##6 (o_status == tbc_pkg::ST_DEGEN))
        else $error("zero triangle not reported as degenerate");

    // The index is zero whenever the status is not a valid index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != tbc_pkg::ST_OK)) |-> (o_triangle_index == '0))
        else $error("nonzero index with error status");

endmodule

>>> verif/tbc_verdict_monitor.sv
`timescale 1ns / 1ps

module tbc_verdict_monitor
    import tbc_pkg::*;
#(
    parameter int MAX_BINS = MAX_BINS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  i_func,
    input  logic [LEN_PORT_W-1:0] i_len_a,
    input  logic [LEN_PORT_W-1:0] i_len_b,
    input  logic [LEN_PORT_W-1:0] i_len_c,
    input  logic [SLOT_W-1:0]     i_edge_slot,
    input  logic [LEN_PORT_W-1:0] i_edge_value,
    input  logic                  o_done,
    input  logic [STATUS_W-1:0]   o_status,
    input  logic [INDEX_W-1:0]    o_triangle_index,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output int                    o_pending,
    output int                    o_fail_count
);

    // Each classify verdict is predicted when its transaction is accepted
    // and compared, in order, with the result strobes.
    typedef struct packed {
        t_status            status;
        logic [INDEX_W-1:0] index;
    } t_verdict;

    logic [LEN_PORT_W-1:0] edge_table [MAX_BINS+1];
    logic [CFG_W-1:0]      bins_reg;
    t_verdict              verdicts_q [$];

    // The highest bin whose half-open range holds x, or -1.
    function automatic int locate_bin(logic [LEN_PORT_W-1:0] x, int n);
        int hit;
        hit = -1;
        for (int i = 0; i < n; i++)
            if (x >= edge_table[i] && x < edge_table[i+1]) hit = i;
        return hit;
    endfunction

    function automatic t_verdict classify_triangle(logic [LEN_PORT_W-1:0] x0,
                                                   logic [LEN_PORT_W-1:0] x1,
                                                   logic [LEN_PORT_W-1:0] x2);
        logic [LEN_PORT_W-1:0] lo, mid, hi, tmp;
        logic [65:0]           side_sum, gap;
        int                    n, bin_lo, bin_mid, bin_hi, flat;
        t_verdict              v;
        lo  = x0;
        mid = x1;
        hi  = x2;
        if (lo > mid) begin
            tmp = lo; lo = mid; mid = tmp;
        end
        if (lo > hi) begin
            tmp = lo; lo = hi; hi = tmp;
        end
        if (mid > hi) begin
            tmp = mid; mid = hi; hi = tmp;
        end
        v.status = ST_OK;
        v.index  = '0;
        // Exact form of sqrt(lo) + sqrt(mid) <= sqrt(hi), kept wide enough
        // that 4*lo*mid cannot overflow.
        side_sum = 66'(lo) + 66'(mid);
        if (66'(hi) >= side_sum) begin
            gap = 66'(hi) - side_sum;
            if (66'(4) * 66'(lo) * 66'(mid) <= gap * gap) begin
                v.status = ST_DEGEN;
                return v;
            end
        end
        n       = (bins_reg > MAX_BINS) ? MAX_BINS : int'(bins_reg);
        bin_lo  = locate_bin(lo, n);
        bin_mid = locate_bin(mid, n);
        bin_hi  = locate_bin(hi, n);
        if (bin_lo < 0 || bin_mid < 0 || bin_hi < 0) begin
            v.status = ST_NO_BIN;
            return v;
        end
        flat    = bin_hi + bin_mid * n + bin_lo * n * n;
        v.index = flat[INDEX_W-1:0];
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            bins_reg = BINS_RESET;
            verdicts_q.delete();
        end else begin
            if (o_done) begin
                if (verdicts_q.size() == 0) begin
                    $error("result strobe with no classify transaction outstanding");
                    o_fail_count++;
                end else begin
                    want = verdicts_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        o_fail_count++;
                    end
                    if (o_triangle_index !== want.index) begin
                        $error("triangle_index: expected %0d, actual %0d",
                               want.index, o_triangle_index);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready)
                bins_reg = i_cfg_data;
            if (start && !busy) begin
                if (i_func == FUNC_LOAD) begin
                    if (i_edge_slot <= MAX_BINS)
                        edge_table[i_edge_slot] = i_edge_value;
                end else begin
                    verdicts_q.insert(verdicts_q.size(),
                                      classify_triangle(i_len_a, i_len_b, i_len_c));
                end
            end
        end
        o_pending <= verdicts_q.size();
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tbc_pkg::*;

    localparam int N_EDGES         = MAX_BINS_DEF + 1;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 100;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  start            = 1'b0;
    logic                  busy;
    logic                  i_func           = FUNC_LOAD;
    logic [LEN_PORT_W-1:0] i_len_a          = '0;
    logic [LEN_PORT_W-1:0] i_len_b          = '0;
    logic [LEN_PORT_W-1:0] i_len_c          = '0;
    logic [SLOT_W-1:0]     i_edge_slot      = '0;
    logic [LEN_PORT_W-1:0] i_edge_value     = '0;
    logic                  o_done;
    logic [STATUS_W-1:0]   o_status;
    logic [INDEX_W-1:0]    o_triangle_index;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data       = '0;

    int pending;
    int fails;

    // The stimulus keeps its own picture of the loaded edges and the bin
    // count, only so that it can aim lengths at bins and at bin boundaries.
    logic [LEN_PORT_W-1:0] edge_plan [N_EDGES];
    int                    plan_bins = BINS_RESET;
    // Chance, in percent, that the sender stays quiet in a given cycle.
    int                    idle_pct  = 0;

    triangle_bin_classifier_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_len_a          (i_len_a),
        .i_len_b          (i_len_b),
        .i_len_c          (i_len_c),
        .i_edge_slot      (i_edge_slot),
        .i_edge_value     (i_edge_value),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_triangle_index (o_triangle_index),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    tbc_verdict_monitor u_verdict_mon (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_len_a          (i_len_a),
        .i_len_b          (i_len_b),
        .i_len_c          (i_len_c),
        .i_edge_slot      (i_edge_slot),
        .i_edge_value     (i_edge_value),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_triangle_index (o_triangle_index),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending),
        .o_fail_count     (fails)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or a verdict never comes back.
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // Drives one item and returns at the edge where it is accepted. Before
    // the item the sender may stay quiet for some cycles, each with the idle
    // chance. Start is left high after acceptance, so back-to-back
    // transactions never lower and raise start within one time step.
    task automatic send_item(input logic func, input logic [LEN_PORT_W-1:0] a,
                             input logic [LEN_PORT_W-1:0] b,
                             input logic [LEN_PORT_W-1:0] c,
                             input logic [SLOT_W-1:0] slot,
                             input logic [LEN_PORT_W-1:0] value);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= func;
        i_len_a      <= a;
        i_len_b      <= b;
        i_len_c      <= c;
        i_edge_slot  <= slot;
        i_edge_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // The unused fields carry random junk so that their bits toggle too.
    task automatic send_load(input logic [SLOT_W-1:0] slot,
                             input logic [LEN_PORT_W-1:0] value);
        send_item(FUNC_LOAD, $urandom(), $urandom(), $urandom(), slot, value);
        if (slot < N_EDGES)
            edge_plan[slot] = value;
    endtask

    task automatic send_classify(input logic [LEN_PORT_W-1:0] a,
                                 input logic [LEN_PORT_W-1:0] b,
                                 input logic [LEN_PORT_W-1:0] c);
        send_item(FUNC_CLASSIFY, a, b, c, SLOT_W'($urandom_range(0, 31)), $urandom());
    endtask

    // Drops start, waits until every predicted verdict has come back, then
    // lets the pipeline run dry of loads as well. Configuration is only
    // written after this.
    task automatic settle_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_bins(input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        plan_bins = value;
    endtask

    // Fills every edge slot, so no classify ever reads an unwritten edge.
    // Shape 0 spreads sorted edges over the whole 32-bit range (the top
    // edge stays below all ones), shape 1 packs even bins into the low
    // 21 bits, and shape 2 is unsorted noise where overlapping bins make
    // the highest match win.
    task automatic load_edge_table(input int shape);
        logic [LEN_PORT_W-1:0] base, stride, value;
        base   = $urandom_range(0, 1000);
        stride = (shape == 1) ? $urandom_range(1, 65536) : 32'h0FFF_0000;
        for (int s = 0; s < N_EDGES; s++) begin
            if (shape == 2)
                value = $urandom();
            else if (shape == 1)
                value = base + s * stride;
            else
                value = base + s * stride + $urandom_range(0, 16'hFFFF);
            send_load(SLOT_W'(s), value);
        end
    endtask

    // One squared length: most often inside a live bin, sometimes right on or
    // next to an edge, sometimes tiny, sometimes anything at all.
    function automatic logic [LEN_PORT_W-1:0] pick_length();
        int                    mode, nb, i;
        logic [LEN_PORT_W-1:0] lo_e, hi_e;
        nb   = (plan_bins > MAX_BINS_DEF) ? MAX_BINS_DEF : plan_bins;
        mode = $urandom_range(0, 9);
        if (mode < 2)
            return $urandom();
        if (mode < 6 && nb > 0) begin
            i    = $urandom_range(0, nb - 1);
            lo_e = edge_plan[i];
            hi_e = edge_plan[i+1];
            if (hi_e > lo_e)
                return lo_e + ($urandom() % (hi_e - lo_e));
            return lo_e;
        end
        if (mode < 8)
            return edge_plan[$urandom_range(0, N_EDGES - 1)] + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 255);
    endfunction

    // One random transaction. Loads to slots past the table are dropped by
    // the block, so they are not counted.
    task automatic random_item(output int counted);
        logic [LEN_PORT_W-1:0] a, b, c, p, q, s;
        int                    roll;
        roll    = $urandom_range(0, 99);
        counted = 1;
        if (roll < 9) begin
            send_load(SLOT_W'($urandom_range(0, MAX_BINS_DEF)),
                      $urandom_range(0, 1) ? $urandom() : pick_length());
            return;
        end
        if (roll < 12) begin
            send_load(SLOT_W'($urandom_range(MAX_BINS_DEF + 1, 31)), $urandom());
            counted = 0;
            return;
        end
        if (roll < 32) begin
            // Perfect squares whose roots just meet, just pass or just fail
            // the triangle inequality.
            p = $urandom_range(0, 32767);
            q = $urandom_range(0, 32767);
            s = p + q;
            a = p * p;
            b = q * q;
            c = s * s + $urandom_range(0, 2) - 1;
        end else begin
            a = pick_length();
            b = pick_length();
            c = pick_length();
        end
        // Present the sides in a random order so the sorting is exercised.
        if ($urandom_range(0, 1)) {a, c} = {c, a};
        if ($urandom_range(0, 1)) {b, c} = {c, b};
        if ($urandom_range(0, 1)) {a, b} = {b, a};
        send_classify(a, b, c);
    endtask

    initial begin
        int sent, counted;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset bin count of sixteen. The whole
        // table is loaded before the first classify.
        load_edge_table(0);
        send_classify('0, '0, '0);               // all zero is degenerate
        send_classify('1, '1, '1);               // above the top edge
        send_classify('0, '0, '1);               // degenerate beats out-of-bin
        // Roots 20000 + 30000 = 50000 exactly, then one unit either way.
        send_classify(32'd400000000, 32'd900000000, 32'd2500000000);
        send_classify(32'd2499999999, 32'd900000000, 32'd400000000);
        send_classify(32'd900000000, 32'd2500000001, 32'd400000000);
        // Lengths sitting exactly on edges, then one below.
        send_classify(edge_plan[3], edge_plan[5], edge_plan[7]);
        send_classify(edge_plan[4] - 1, edge_plan[6] - 1, edge_plan[8] - 1);
        // A load followed at once by a classify that depends on it; the
        // short side falls below the first edge.
        send_load(SLOT_W'(0), 32'd1000);
        send_classify(32'd5, edge_plan[1], edge_plan[1]);
        // Loads past the last slot must leave the table alone.
        send_load(SLOT_W'(17), '0);
        send_load(SLOT_W'(31), '0);
        send_classify(edge_plan[0], edge_plan[0], edge_plan[0]);
        // No bins at all: a good triangle can only miss.
        settle_pipeline();
        write_bins(0);
        send_classify(edge_plan[2], edge_plan[2], edge_plan[2]);
        // A count above the table size acts as the full table; the last
        // bin on all three sides gives the largest flat index.
        settle_pipeline();
        write_bins(31);
        send_classify(edge_plan[15], edge_plan[15], edge_plan[15]);
        settle_pipeline();
        write_bins(1);
        send_classify(edge_plan[0], edge_plan[0], edge_plan[0]);

        // Random phases. Each one settles, picks a bin count (extremes
        // included), reloads the table and runs with its own idling.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle_pipeline();
            case (ph)
                0: write_bins(16);
                1: write_bins(1);
                2: write_bins(0);
                3: write_bins(31);
                4: write_bins(17);
                5: write_bins(5);
                6: write_bins(2);
                7: write_bins(12);
                8: write_bins(16);
                default: write_bins($urandom_range(0, 31));
            endcase
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 45;
                default: idle_pct = 36;
            endcase
            load_edge_table(ph % 3);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                random_item(counted);
                sent += counted;
            end
        end

        settle_pipeline();
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/tbc_pkg.sv
hw/rtl/tbc_bin_lookup.sv
hw/rtl/triangle_bin_classifier_unit.sv
verif/tbc_verdict_monitor.sv
verif/testbench.sv
